// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the panel sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a result in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pps_pkg.sv -----
// Types, constants and the microcode program of the panel power sequencer.
package pps_pkg;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t S_FETCH    = 4'd0;
  localparam upc_t S_DISPATCH = 4'd1;
  localparam upc_t S_WRITE    = 4'd2;
  localparam upc_t S_BLANK    = 4'd3;
  localparam upc_t S_TICK     = 4'd4;
  localparam upc_t S_POLL     = 4'd5;
  localparam upc_t S_HDR      = 4'd6;
  localparam upc_t S_SCAN     = 4'd7;
  localparam upc_t S_PIX      = 4'd8;
  localparam upc_t S_STEP     = 4'd9;
  localparam upc_t S_FINISH   = 4'd10;
  localparam upc_t S_DONE     = 4'd11;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_POLL,
    CMD_WRITE,
    CMD_BLANK
  } cmd_t;

  // Adding this to a command code gives its slot after S_WRITE.
  localparam logic [1:0] CMD_SLOT_ROT = 2'd2;

  typedef enum logic [2:0] {
    PH_DISCHARGE,
    PH_3V3_OFF,
    PH_3V3_ON,
    PH_12V_ON,
    PH_RUNNING
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK,
    OP_PHASE,
    OP_WRITE,
    OP_BLANK,
    OP_HDR,
    OP_PIX,
    OP_ADV,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_CMD,
    C_NO_FRAME,
    C_OUT_BUSY,
    C_CLEAN,
    C_PIX_BUSY,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic in_taken;
    cmd_t cmd;
    logic out_free;
    logic frame_ok;
    logic pix_clean;
    logic ch_last;
    logic more;
  } stat_t;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_DISCHARGE = 2'd0;
  localparam logic [1:0] REG_OFF       = 2'd1;
  localparam logic [1:0] REG_ON        = 2'd2;
  localparam logic [1:0] REG_RAIL      = 2'd3;

  localparam logic [7:0] DISCHARGE_WAIT_RST = 8'd10;
  localparam logic [7:0] OFF_WAIT_RST       = 8'd4;
  localparam logic [7:0] ON_WAIT_RST        = 8'd1;
  localparam logic [7:0] RAIL_WAIT_RST      = 8'd1;

  localparam logic [7:0] FRAME_HDR   = 8'hF0;
  localparam logic [7:0] GREEN_RST   = 8'd200;
  localparam logic [7:0] SECONDS_MAX = 8'd255;
  localparam logic [1:0] CH_RED      = 2'd0;
  localparam logic [1:0] CH_GREEN    = 2'd1;
  localparam logic [1:0] CH_BLUE     = 2'd2;

  function automatic ctrl_t ucode(upc_t step);
    ctrl_t c;
    unique case (step)
      S_FETCH:    c = '{OP_LATCH, C_NO_INPUT, S_FETCH};
      S_DISPATCH: c = '{OP_NONE,  C_CMD,      S_WRITE};
      S_WRITE:    c = '{OP_WRITE, C_ALWAYS,   S_DONE};
      S_BLANK:    c = '{OP_BLANK, C_ALWAYS,   S_DONE};
      S_TICK:     c = '{OP_TICK,  C_ALWAYS,   S_DONE};
      S_POLL:     c = '{OP_PHASE, C_NO_FRAME, S_DONE};
      S_HDR:      c = '{OP_HDR,   C_OUT_BUSY, S_HDR};
      S_SCAN:     c = '{OP_NONE,  C_CLEAN,    S_STEP};
      S_PIX:      c = '{OP_PIX,   C_PIX_BUSY, S_PIX};
      S_STEP:     c = '{OP_ADV,   C_MORE,     S_SCAN};
      S_FINISH:   c = '{OP_NONE,  C_ALWAYS,   S_FETCH};
      S_DONE:     c = '{OP_DONE,  C_OUT_BUSY, S_DONE};
      default:    c = '{OP_NONE,  C_ALWAYS,   S_FETCH};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/pps_seq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
`include "assert_macros.svh"

module pps_seq (
  input  logic            clk,
  input  logic            rst,
  input  pps_pkg::stat_t  stat,
  output pps_pkg::ctrl_t  ctrl
);

  pps_pkg::upc_t upc;
  pps_pkg::upc_t upc_next;
  logic [1:0]    slot;
  logic          taken;

  assign ctrl = pps_pkg::ucode(upc);

  always_comb begin
    slot = 2'(stat.cmd) + pps_pkg::CMD_SLOT_ROT;
    unique case (ctrl.cond)
      pps_pkg::C_ALWAYS:   taken = 1'b1;
      pps_pkg::C_NO_INPUT: taken = !stat.in_taken;
      pps_pkg::C_CMD:      taken = 1'b1;
      pps_pkg::C_NO_FRAME: taken = !stat.frame_ok;
      pps_pkg::C_OUT_BUSY: taken = !stat.out_free;
      pps_pkg::C_CLEAN:    taken = stat.pix_clean;
      pps_pkg::C_PIX_BUSY: taken = !(stat.out_free && stat.ch_last);
      pps_pkg::C_MORE:     taken = stat.more;
      default:             taken = 1'b1;
    endcase
    if (ctrl.cond == pps_pkg::C_CMD) begin
      upc_next = ctrl.target + pps_pkg::upc_t'(slot);
    end else if (taken) begin
      upc_next = ctrl.target;
    end else begin
      upc_next = upc + pps_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= pps_pkg::S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  `ASSERT_NEXT(a_dispatch_range, ctrl.cond == pps_pkg::C_CMD, upc >= pps_pkg::S_WRITE && upc <= pps_pkg::S_POLL, "Dispatch left the command steps.")
  `ASSERT_NEXT(a_fetch_holds, upc == pps_pkg::S_FETCH && !stat.in_taken, upc == pps_pkg::S_FETCH, "Fetch step left without a transfer.")
  `ASSERT_NEXT(a_pix_holds, upc == pps_pkg::S_PIX && !(stat.out_free && stat.ch_last), upc == pps_pkg::S_PIX, "Pixel step left before its blue byte.")

endmodule

// ----- rtl/core/pps_dpath.sv -----
// Datapath: item latch, power phase, pixel store and the output register.
`include "assert_macros.svh"

module pps_dpath #(
  parameter int PIXEL_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  pps_pkg::ctrl_t  ctrl,
  output pps_pkg::stat_t  stat,
  input  logic [7:0]      discharge_wait,
  input  logic [7:0]      off_wait,
  input  logic [7:0]      on_wait,
  input  logic [7:0]      rail_wait,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      cmd,
  input  logic            link_idle,
  input  logic [1:0]      pixel_index,
  input  logic [7:0]      red_value,
  input  logic [7:0]      green_value,
  input  logic [7:0]      blue_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            rail_3v3_pin,
  output logic            rail_12v_pin,
  output logic            byte_valid,
  output logic [7:0]      tx_byte,
  output logic            last
);

  localparam int PTR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [2:0] PIX_LIMIT = 3'(PIXEL_COUNT);

  pps_pkg::cmd_t   item_cmd;
  logic            item_idle;
  logic [1:0]      item_idx;
  logic [7:0]      item_r;
  logic [7:0]      item_g;
  logic [7:0]      item_b;

  pps_pkg::phase_t phase;
  logic [7:0]      seconds;
  logic            pin_3v3;
  logic            pin_12v;
  logic [7:0]      pix_r [PIXEL_COUNT];
  logic [7:0]      pix_g [PIXEL_COUNT];
  logic [7:0]      pix_b [PIXEL_COUNT];
  logic [PIXEL_COUNT-1:0] dirty;
  logic [PTR_W-1:0] ptr;
  logic [1:0]      ch;

  logic            in_taken;
  logic            out_free;
  logic            out_load;
  logic            more;
  logic            pix_clean;
  logic            ch_last;
  logic [7:0]      cur_r;
  logic [7:0]      cur_g;
  logic [7:0]      cur_b;
  logic [2:0]      level;
  logic [3:0]      chan;

  assign in_stall = rst || (ctrl.op != pps_pkg::OP_LATCH);
  assign in_taken = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = out_free && ((ctrl.op == pps_pkg::OP_HDR) || (ctrl.op == pps_pkg::OP_PIX) ||
                                 (ctrl.op == pps_pkg::OP_DONE));
  assign ch_last  = (ch == pps_pkg::CH_BLUE);

  always_comb begin
    more      = 1'b0;
    pix_clean = 1'b1;
    cur_r     = '0;
    cur_g     = '0;
    cur_b     = '0;
    for (int j = 0; j < PIXEL_COUNT; j++) begin
      if (dirty[j] && (PTR_W'(j) > ptr)) begin
        more = 1'b1;
      end
      if (PTR_W'(j) == ptr) begin
        pix_clean = !dirty[j];
        cur_r     = pix_r[j];
        cur_g     = pix_g[j];
        cur_b     = pix_b[j];
      end
    end
    unique case (ch)
      pps_pkg::CH_RED:   level = cur_r[7:5];
      pps_pkg::CH_GREEN: level = cur_g[7:5];
      pps_pkg::CH_BLUE:  level = cur_b[7:5];
      default:           level = 3'd0;
    endcase
    chan = (4'(ptr) << 1) + 4'(ptr) + 4'(ch);
  end

  always_comb begin
    stat.in_taken  = in_taken;
    stat.cmd       = item_cmd;
    stat.out_free  = out_free;
    stat.frame_ok  = (phase == pps_pkg::PH_RUNNING) && item_idle && (|dirty);
    stat.pix_clean = pix_clean;
    stat.ch_last   = ch_last;
    stat.more      = more;
  end

  always_ff @(posedge clk) begin
    if (in_taken) begin
      item_cmd  <= pps_pkg::cmd_t'(cmd);
      item_idle <= link_idle;
      item_idx  <= pixel_index;
      item_r    <= red_value;
      item_g    <= green_value;
      item_b    <= blue_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pps_pkg::PH_DISCHARGE;
      seconds   <= '0;
      pin_3v3   <= 1'b1;
      pin_12v   <= 1'b0;
      dirty     <= '1;
      ptr       <= '0;
      ch        <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < PIXEL_COUNT; j++) begin
        pix_r[j] <= '0;
        pix_g[j] <= pps_pkg::GREEN_RST;
        pix_b[j] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        pps_pkg::OP_TICK: begin
          if (seconds != pps_pkg::SECONDS_MAX) begin
            seconds <= seconds + 8'd1;
          end
        end
        pps_pkg::OP_PHASE: begin
          unique case (phase)
            pps_pkg::PH_DISCHARGE: begin
              if (seconds > discharge_wait) begin
                phase   <= pps_pkg::PH_3V3_OFF;
                seconds <= '0;
                pin_3v3 <= 1'b1;
                pin_12v <= 1'b0;
              end
            end
            pps_pkg::PH_3V3_OFF: begin
              if (seconds > off_wait) begin
                phase   <= pps_pkg::PH_3V3_ON;
                seconds <= '0;
                pin_3v3 <= 1'b0;
                pin_12v <= 1'b0;
              end
            end
            pps_pkg::PH_3V3_ON: begin
              if (seconds > on_wait) begin
                phase   <= pps_pkg::PH_12V_ON;
                seconds <= '0;
                pin_12v <= 1'b1;
              end
            end
            pps_pkg::PH_12V_ON: begin
              if (seconds > rail_wait) begin
                phase <= pps_pkg::PH_RUNNING;
              end
            end
            pps_pkg::PH_RUNNING: begin
            end
            default: begin
              phase   <= pps_pkg::PH_DISCHARGE;
              seconds <= '0;
              pin_3v3 <= 1'b1;
            end
          endcase
        end
        pps_pkg::OP_WRITE: begin
          for (int j = 0; j < PIXEL_COUNT; j++) begin
            if (({1'b0, item_idx} < PIX_LIMIT) && (item_idx == 2'(j))) begin
              pix_r[j] <= item_r;
              pix_g[j] <= item_g;
              pix_b[j] <= item_b;
              dirty[j] <= 1'b1;
            end
          end
        end
        pps_pkg::OP_BLANK: begin
          dirty <= '1;
          for (int j = 0; j < PIXEL_COUNT; j++) begin
            pix_r[j] <= '0;
            pix_g[j] <= '0;
            pix_b[j] <= '0;
          end
        end
        pps_pkg::OP_HDR: begin
          if (out_free) begin
            byte_valid   <= 1'b1;
            tx_byte      <= pps_pkg::FRAME_HDR;
            last         <= 1'b0;
            rail_3v3_pin <= pin_3v3;
            rail_12v_pin <= pin_12v;
            ptr          <= '0;
            ch           <= pps_pkg::CH_RED;
          end
        end
        pps_pkg::OP_PIX: begin
          if (out_free) begin
            byte_valid   <= 1'b1;
            tx_byte      <= {chan, 1'b0, level};
            last         <= ch_last && !more;
            rail_3v3_pin <= pin_3v3;
            rail_12v_pin <= pin_12v;
            if (ch_last) begin
              ch <= pps_pkg::CH_RED;
              for (int j = 0; j < PIXEL_COUNT; j++) begin
                if (PTR_W'(j) == ptr) begin
                  dirty[j] <= 1'b0;
                end
              end
            end else begin
              ch <= ch + 2'd1;
            end
          end
        end
        pps_pkg::OP_ADV: begin
          if (more) begin
            ptr <= ptr + PTR_W'(1);
          end
        end
        pps_pkg::OP_DONE: begin
          if (out_free) begin
            byte_valid   <= 1'b0;
            tx_byte      <= '0;
            last         <= 1'b1;
            rail_3v3_pin <= pin_3v3;
            rail_12v_pin <= pin_12v;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NOW(a_running_pins, phase != pps_pkg::PH_RUNNING || (pin_12v && !pin_3v3), "Running phase with wrong rail levels.")
  `ASSERT_NEXT(a_count_clear, ctrl.op == pps_pkg::OP_PHASE && phase != pps_pkg::PH_RUNNING, seconds == 8'd0 || phase == $past(phase) || phase == pps_pkg::PH_RUNNING, "Phase change left the seconds counter set.")
  `ASSERT_NOW(a_header_dirty, ctrl.op != pps_pkg::OP_HDR || (|dirty), "Frame header with no dirty pixel.")

endmodule

// ----- rtl/core/panel_power_sequencer_and_frame_packer_top.sv -----
// Panel power sequencer and frame packer: configuration registers and core.
// A tick, write, blank or non-sending poll ends at the done step, which loads the output register.
// A sending poll emits the header, then three channel bytes per dirty pixel, skipping clean ones.
// The steps are set by the microcode program, which runs one control word per cycle.
// Output stall holds the sequencer at its current emit step.
// Reset is synchronous: the sequencer returns to fetch; all else but item latch and byte/rail outputs resets.
module panel_power_sequencer_and_frame_packer_top #(
  parameter int PIXEL_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pps_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      cmd,
  input  logic                            link_idle,
  input  logic [1:0]                      pixel_index,
  input  logic [7:0]                      red_value,
  input  logic [7:0]                      green_value,
  input  logic [7:0]                      blue_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            rail_3v3_pin,
  output logic                            rail_12v_pin,
  output logic                            byte_valid,
  output logic [7:0]                      tx_byte,
  output logic                            last
);

  logic [7:0]     discharge_wait;
  logic [7:0]     off_wait;
  logic [7:0]     on_wait;
  logic [7:0]     rail_wait;
  logic [1:0]     reg_index;
  logic           cfg_write;
  pps_pkg::ctrl_t ctrl;
  pps_pkg::stat_t stat;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      discharge_wait <= pps_pkg::DISCHARGE_WAIT_RST;
      off_wait       <= pps_pkg::OFF_WAIT_RST;
      on_wait        <= pps_pkg::ON_WAIT_RST;
      rail_wait      <= pps_pkg::RAIL_WAIT_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        pps_pkg::REG_DISCHARGE: discharge_wait <= pwdata[7:0];
        pps_pkg::REG_OFF:       off_wait       <= pwdata[7:0];
        pps_pkg::REG_ON:        on_wait        <= pwdata[7:0];
        pps_pkg::REG_RAIL:      rail_wait      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      pps_pkg::REG_DISCHARGE: prdata = pps_pkg::APB_DATA_W'(discharge_wait);
      pps_pkg::REG_OFF:       prdata = pps_pkg::APB_DATA_W'(off_wait);
      pps_pkg::REG_ON:        prdata = pps_pkg::APB_DATA_W'(on_wait);
      pps_pkg::REG_RAIL:      prdata = pps_pkg::APB_DATA_W'(rail_wait);
      default:                prdata = '0;
    endcase
  end

  pps_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  pps_dpath #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .discharge_wait (discharge_wait),
    .off_wait       (off_wait),
    .on_wait        (on_wait),
    .rail_wait      (rail_wait),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .link_idle      (link_idle),
    .pixel_index    (pixel_index),
    .red_value      (red_value),
    .green_value    (green_value),
    .blue_value     (blue_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rail_3v3_pin   (rail_3v3_pin),
    .rail_12v_pin   (rail_12v_pin),
    .byte_valid     (byte_valid),
    .tx_byte        (tx_byte),
    .last           (last)
  );

endmodule
